### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of i_clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tks_pkg.sv
// ---------------------------------------------------------------------------
// tks_pkg
// Types and constants shared by the score table cells and the top level.
// ---------------------------------------------------------------------------
package tks_pkg;

    localparam int SCORE_W   = 32;
    localparam int CHARS_W   = 64;
    localparam int CHARS_H_W = 32;
    localparam int NAME_BYTES = 20;
    localparam int RANK_W    = 4;

    // Beat kinds on the input stream.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // One stored record: score and the three name words.
    typedef struct packed {
        logic [SCORE_W-1:0]   score;
        logic [CHARS_W-1:0]   chars_lo;
        logic [CHARS_W-1:0]   chars_mid;
        logic [CHARS_H_W-1:0] chars_hi;
    } t_record;

    // Operation applied to every cell of the chain in the same cycle.
    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctl;

endpackage

### hw/rtl/top_k_score_table.sv
// ---------------------------------------------------------------------------
// top_k_score_table
// Sorted table of the best scores with their names, kept in a chain of cells.
// ---------------------------------------------------------------------------
// Channel  | Dir | Beat content
// s_axis   | in  | tuser: kind; tdata: score, name chars 0-7, 8-15, 16-19
// m_axis   | out | tuser: table_empty; tlast: last_entry;
//          |     | tdata: rank, score, name chars 0-7, 8-15, 16-19
//
// An insert beat is registered into the chain, and a new one can follow every cycle while no read-out runs.
// A read beat rotates the ring of cells once, holding while a stalled output
// blocks the next entry; an empty table answers with a single beat.
// No input beat is taken during a read-out. The output register lets the
// next input beat in while the last result still waits.
// Reset is synchronous, active low, and empties the table.
// ---------------------------------------------------------------------------
module top_k_score_table #(
    parameter int TABLE_ENTRIES = 10,
    parameter int NAME_CHARS    = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] new_score, [95:32] name_chars_0_7, [159:96] name_chars_8_15,
    // [191:160] name_chars_16_19
    input  logic [191:0] s_axis_tdata,
    // [0] kind
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] rank, [35:4] entry_score, [99:36] entry_chars_0_7,
    // [163:100] entry_chars_8_15, [195:164] entry_chars_16_19, [199:196] zero
    output logic [199:0] m_axis_tdata,
    // [0] table_empty
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ROT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ROT_W-1:0] r_rot, n_rot;

    logic             r_out_valid, n_out_valid;
    tks_pkg::t_record r_out_rec, n_out_rec;
    logic [tks_pkg::RANK_W-1:0] r_out_rank, n_out_rank;
    logic             r_out_empty, n_out_empty;
    logic             r_out_last, n_out_last;

    logic             w_in_fire;
    logic             w_kind_read;
    logic             w_full;
    logic             w_table_empty;
    logic             w_emit_now;
    logic             w_slot_free;
    logic             w_advance;
    logic             w_rot_done;
    logic [CNT_W+3:0] w_rank_ext;
    tks_pkg::t_record w_new_rec;
    tks_pkg::t_cell_ctl w_ctl;

    tks_pkg::t_record w_rec [TABLE_ENTRIES];
    logic             w_ge  [TABLE_ENTRIES];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_kind_read   = (s_axis_tuser == tks_pkg::KIND_READ);
    assign w_full        = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_table_empty = (r_count == '0);

    // Name clean-up: everything from the first zero byte on is cleared, and so
    // is every byte past the configured name length.
    always_comb begin
        logic [tks_pkg::NAME_BYTES*8-1:0] name;
        logic ended;
        name  = s_axis_tdata[191:32];
        ended = 1'b0;
        for (int b = 0; b < tks_pkg::NAME_BYTES; b++) begin
            if (b >= NAME_CHARS || name[b*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (ended) begin
                name[b*8 +: 8] = 8'h00;
            end
        end
        w_new_rec.score     = s_axis_tdata[31:0];
        w_new_rec.chars_lo  = name[63:0];
        w_new_rec.chars_mid = name[127:64];
        w_new_rec.chars_hi  = name[159:128];
    end

    // Read-out step control.
    assign w_emit_now  = w_table_empty || (CNT_W'(r_rot) < r_count);
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_advance   = (r_state == ST_READ) && (!w_emit_now || w_slot_free);
    assign w_rot_done  = w_table_empty || (r_rot == ROT_W'(TABLE_ENTRIES - 1));
    assign w_rank_ext  = (CNT_W+4)'(r_rot) + (CNT_W+4)'(1);

    assign w_ctl.insert = w_in_fire && !w_kind_read;
    assign w_ctl.rotate = w_advance && !w_table_empty;

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        localparam int PREV = (gi == 0) ? 0 : gi - 1;
        localparam int NEXT = (gi + 1) % TABLE_ENTRIES;

        tks_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CNT_W'(gi) < r_count),
            .i_prev_ge  ((gi == 0) ? 1'b1 : w_ge[PREV]),
            .i_new_rec  (w_new_rec),
            .i_prev_rec ((gi == 0) ? w_new_rec : w_rec[PREV]),
            .i_next_rec (w_rec[NEXT]),
            .o_rec      (w_rec[gi]),
            .o_ge       (w_ge[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rot       = r_rot;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_rec   = r_out_rec;
        n_out_rank  = r_out_rank;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (w_kind_read) begin
                        n_state = ST_READ;
                        n_rot   = '0;
                    end else if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_READ: begin
                if (w_advance) begin
                    if (w_emit_now) begin
                        n_out_valid = 1'b1;
                        if (w_table_empty) begin
                            n_out_rec   = '0;
                            n_out_rank  = '0;
                            n_out_empty = 1'b1;
                            n_out_last  = 1'b1;
                        end else begin
                            // Slot zero always holds the entry being read out.
                            n_out_rec   = w_rec[0];
                            n_out_rank  = w_rank_ext[tks_pkg::RANK_W-1:0];
                            n_out_empty = 1'b0;
                            n_out_last  = ((CNT_W'(r_rot) + CNT_W'(1)) == r_count);
                        end
                    end
                    if (w_rot_done) begin
                        n_state = ST_IDLE;
                        n_rot   = '0;
                    end else begin
                        n_rot = r_rot + ROT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rot       <= n_rot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rec   <= n_out_rec;
        r_out_rank  <= n_out_rank;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_rec.chars_hi, r_out_rec.chars_mid,
                            r_out_rec.chars_lo, r_out_rec.score, r_out_rank};
    assign m_axis_tuser  = r_out_empty;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_CLK(a_count_max, r_count <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
    `ASSERT_NEXT(a_ins_grow, w_in_fire && !w_kind_read && !w_full, r_count == $past(r_count) + CNT_W'(1), "insert did not grow the table")
    `ASSERT_NEXT(a_read_count, r_state == ST_READ, $stable(r_count), "entry count changed during read-out")
    `ASSERT_NEXT(a_stall_hold, r_state == ST_READ && w_emit_now && r_out_valid && !m_axis_tready, $stable(r_rot), "ring rotated while output stalled")
    `ASSERT_CLK(a_empty_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "empty-table beat without last mark")

endmodule

### hw/rtl/tks_cell.sv
// ---------------------------------------------------------------------------
// tks_cell
// One slot of the ranking chain. On an insert it keeps its record, takes the
// new record, or takes its upper neighbor's record; on a rotate it takes its
// lower neighbor's record so the chain can be read out at slot zero.
// ---------------------------------------------------------------------------
module tks_cell (
    input  logic               i_clk,
    input  tks_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_ge,
    input  tks_pkg::t_record   i_new_rec,
    input  tks_pkg::t_record   i_prev_rec,
    input  tks_pkg::t_record   i_next_rec,
    output tks_pkg::t_record   o_rec,
    output logic               o_ge
);

    tks_pkg::t_record r_rec;
    tks_pkg::t_record n_rec;

    // A stored score equal to the new one ranks ahead of it.
    assign o_ge  = i_occupied && ($signed(r_rec.score) >= $signed(i_new_rec.score));
    assign o_rec = r_rec;

    always_comb begin
        n_rec = r_rec;
        priority if (i_ctl.rotate) begin
            n_rec = i_next_rec;
        end else if (i_ctl.insert && !o_ge) begin
            // The first slot below the ranking point takes the new record.
            n_rec = i_prev_ge ? i_new_rec : i_prev_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule
